### src/sgwl_pkg.sv
// Shared constants, types and codes of the start-gap remapper.
`timescale 1ns / 1ps

package sgwl_pkg;

	localparam int MAX_LINES   = 1024;
	localparam int LINE_BYTES  = 64;
	localparam int WEAR_BITS   = 32;

	localparam int ADDR_W      = 32;
	localparam int OUT_W       = 32;
	localparam int MOVES_W     = 32;
	localparam int WPG_W       = 16;
	localparam int CFG_W       = 16;
	localparam int CFG_IDX_W   = 1;

	localparam int OFFSET_BITS = $clog2(LINE_BYTES);
	localparam int LINE_W      = $clog2(MAX_LINES + 1);
	localparam int START_W     = $clog2(MAX_LINES);
	localparam int PHYS_W      = LINE_W + OFFSET_BITS;
	localparam int NUM_W       = ADDR_W - OFFSET_BITS + 1;
	localparam int CNT_W       = $clog2(NUM_W + 1);
	localparam int DEPTH       = MAX_LINES + 1;

	localparam logic [CFG_IDX_W-1:0] REG_LINE_COUNT     = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_WRITES_PER_GAP = CFG_IDX_W'(1);

	localparam logic [LINE_W-1:0] LINE_COUNT_RST = LINE_W'(1000);
	localparam logic [LINE_W-1:0] GAP_RST        = LINE_W'(1000);
	localparam logic [WPG_W-1:0]  WPG_RST        = WPG_W'(2);

	localparam logic [WEAR_BITS-1:0] WEAR_MAX = '1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIV,
		ST_PHYS,
		ST_RD,
		ST_UPD,
		ST_WRAP
	} state_t;

	typedef struct packed {
		logic              go;
		logic [NUM_W-1:0]  num;
		logic [LINE_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [LINE_W-1:0] rem;
	} div_rsp_t;

endpackage

### src/sgwl_div.sv
// Iterative restoring remainder unit, one quotient bit per cycle.
`timescale 1ns / 1ps

module sgwl_div import sgwl_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic              active_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [NUM_W-1:0]  num_q;
	logic [LINE_W-1:0] den_q;
	logic [LINE_W-1:0] rem_q;
	logic [LINE_W:0]   trial;
	logic [LINE_W-1:0] rem_next;

	always_comb begin
		trial = {rem_q, num_q[NUM_W-1]};
		if (trial >= {1'b0, den_q}) begin
			rem_next = LINE_W'(trial - {1'b0, den_q});
		end else begin
			rem_next = trial[LINE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			done_q   <= 1'b0;
			cnt_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				active_q <= 1'b1;
				cnt_q    <= CNT_W'(NUM_W);
			end else if (active_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					active_q <= 1'b0;
					done_q   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			num_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
		end else if (active_q) begin
			num_q <= num_q << 1;
			rem_q <= rem_next;
		end
	end

	assign rsp.done = done_q;
	assign rsp.rem  = rem_q;

endmodule

### src/start_gap_wear_leveling.sv
// Start-gap remapper top level: translation, wear store and gap control.
// The block takes a word when start is high and busy is low, and shows its
// result on the result ports for one cycle marked by done; the receiver cannot
// stall it. Unless the gap wraps, busy drops with the done strobe. First the
// bit-serial remainder unit reduces the rotated line number by the line
// count; then the block hands the remainder over, bumps the line past the gap,
// reads the wear memory and, for a write, writes it back. A write that wraps
// the gap keeps busy high while the same unit reduces the advanced start line.
// After reset a clearing pass zeroes the wear memory with busy high; write
// configuration only while no word is in flight.
`timescale 1ns / 1ps

module start_gap_wear_leveling import sgwl_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 start,
	output logic                 busy,
	input  logic                 cmd,
	input  logic [ADDR_W-1:0]    logical_addr,
	output logic                 done,
	output logic [PHYS_W-1:0]    physical_addr,
	output logic [OUT_W-1:0]     line_wear,
	output logic [OUT_W-1:0]     max_wear,
	output logic                 gap_moved,
	output logic [MOVES_W-1:0]   gap_move_total
);

	state_t state_q, state_d;

	logic [LINE_W-1:0]    line_count_q;
	logic [WPG_W-1:0]     wpg_q;
	logic [START_W-1:0]   start_q;
	logic [LINE_W-1:0]    gap_q;
	logic [WPG_W-1:0]     wc_q;
	logic [WEAR_BITS-1:0] max_q;
	logic [MOVES_W-1:0]   moves_q;
	logic [LINE_W-1:0]    clr_q;
	logic                 done_q;

	logic                 cmd_q;
	logic [LINE_W-1:0]    phys_q;
	logic [WEAR_BITS-1:0] rd_q;
	logic [PHYS_W-1:0]    paddr_q;
	logic [OUT_W-1:0]     wear_out_q;
	logic [OUT_W-1:0]     max_out_q;
	logic                 moved_q;
	logic [MOVES_W-1:0]   moves_out_q;

	logic [LINE_W-1:0]    eff_n;
	logic [LINE_W-1:0]    bumped;
	logic [LINE_W-1:0]    phys_d;
	logic [WEAR_BITS-1:0] wear_inc;
	logic [WEAR_BITS-1:0] max_d;
	logic [WPG_W-1:0]     wc_inc;
	logic [WPG_W-1:0]     psi;
	logic                 move;
	logic                 wrap;
	logic [MOVES_W-1:0]   moves_inc;

	logic                 mem_we;
	logic [LINE_W-1:0]    mem_waddr;
	logic [WEAR_BITS-1:0] mem_wdata;
	logic [WEAR_BITS-1:0] wear_mem [DEPTH];

	div_req_t div_req;
	div_rsp_t div_rsp;

	sgwl_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_comb begin
		priority if (line_count_q == '0) begin
			eff_n = LINE_W'(1);
		end else if (line_count_q > LINE_W'(MAX_LINES)) begin
			eff_n = LINE_W'(MAX_LINES);
		end else begin
			eff_n = line_count_q;
		end
	end

	always_comb begin
		bumped = (div_rsp.rem >= gap_q) ? LINE_W'(div_rsp.rem + 1'b1) : div_rsp.rem;
		phys_d = (bumped > LINE_W'(MAX_LINES)) ? LINE_W'(MAX_LINES) : bumped;
	end

	always_comb begin
		wear_inc  = (rd_q == WEAR_MAX) ? rd_q : rd_q + WEAR_BITS'(1);
		max_d     = (wear_inc > max_q) ? wear_inc : max_q;
		wc_inc    = wc_q + WPG_W'(1);
		psi       = (wpg_q == '0) ? WPG_W'(1) : wpg_q;
		move      = cmd_q && (wc_inc >= psi);
		wrap      = move && (gap_q == '0);
		moves_inc = (moves_q == '1) ? moves_q : moves_q + MOVES_W'(1);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == LINE_W'(MAX_LINES)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) state_d = ST_DIV;
			end
			ST_DIV: begin
				if (div_rsp.done) state_d = ST_PHYS;
			end
			ST_PHYS: state_d = ST_RD;
			ST_RD:   state_d = ST_UPD;
			ST_UPD: begin
				state_d = wrap ? ST_WRAP : ST_IDLE;
			end
			ST_WRAP: begin
				if (div_rsp.done) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		busy        = (state_q != ST_IDLE);
		div_req.go  = ((state_q == ST_IDLE) && start) || ((state_q == ST_UPD) && wrap);
		div_req.den = eff_n;
		if (state_q == ST_IDLE) begin
			div_req.num = NUM_W'(logical_addr[ADDR_W-1:OFFSET_BITS]) + NUM_W'(start_q);
		end else begin
			div_req.num = NUM_W'(start_q) + NUM_W'(1);
		end
		mem_we    = (state_q == ST_CLEAR) || ((state_q == ST_UPD) && cmd_q);
		mem_waddr = (state_q == ST_CLEAR) ? clr_q : phys_q;
		mem_wdata = (state_q == ST_CLEAR) ? '0 : wear_inc;
	end

	always_ff @(posedge clk) begin
		if (mem_we) wear_mem[mem_waddr] <= mem_wdata;
		rd_q <= wear_mem[phys_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_q        <= '0;
			line_count_q <= LINE_COUNT_RST;
			wpg_q        <= WPG_RST;
			start_q      <= '0;
			gap_q        <= GAP_RST;
			wc_q         <= '0;
			max_q        <= '0;
			moves_q      <= '0;
			done_q       <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == ST_UPD);
			if (state_q == ST_CLEAR) clr_q <= clr_q + LINE_W'(1);
			if (cfg_wr_en) begin
				if (cfg_index == REG_LINE_COUNT) line_count_q <= cfg_data[LINE_W-1:0];
				if (cfg_index == REG_WRITES_PER_GAP) wpg_q <= cfg_data[WPG_W-1:0];
			end
			if ((state_q == ST_UPD) && cmd_q) begin
				max_q <= max_d;
				if (move) begin
					wc_q    <= '0;
					moves_q <= moves_inc;
					gap_q   <= (gap_q == '0) ? eff_n : gap_q - LINE_W'(1);
				end else begin
					wc_q <= wc_inc;
				end
			end
			if ((state_q == ST_WRAP) && div_rsp.done) start_q <= div_rsp.rem[START_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && start) cmd_q <= cmd;
		if (state_q == ST_PHYS) phys_q <= phys_d;
		if (state_q == ST_UPD) begin
			paddr_q <= {phys_q, OFFSET_BITS'(0)};
			if (cmd_q) begin
				wear_out_q  <= OUT_W'(wear_inc);
				max_out_q   <= OUT_W'(max_d);
				moved_q     <= move;
				moves_out_q <= move ? moves_inc : moves_q;
			end else begin
				wear_out_q  <= '0;
				max_out_q   <= OUT_W'(max_q);
				moved_q     <= 1'b0;
				moves_out_q <= moves_q;
			end
		end
	end

	assign done           = done_q;
	assign physical_addr  = paddr_q;
	assign line_wear      = wear_out_q;
	assign max_wear       = max_out_q;
	assign gap_moved      = moved_q;
	assign gap_move_total = moves_out_q;

	a_done_after_upd: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q == ST_UPD))
		else $error("result strobe without update cycle");

	a_div_done_expected: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_DIV || state_q == ST_WRAP))
		else $error("remainder unit finished while not awaited");

	a_mem_addr_range: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (mem_waddr <= LINE_W'(MAX_LINES)))
		else $error("wear memory write out of range");

	a_moved_has_wear: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && moved_q) |-> (wear_out_q != '0))
		else $error("gap move reported without a counted write");

	a_busy_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !div_req.go)
		else $error("translation started during clearing pass");

endmodule
